// ===== src/rae_pkg.sv =====
// Package for the register ALU execute block: opcodes, flag type and sizing constants.
// Used by the channel interfaces and by the top level; depends on nothing else.

package rae_pkg;

    // Sizing of the register file and of the data path.
    localparam int REG_COUNT  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // Widths of the item fields, fixed by the instruction format.
    localparam int CMD_W  = 4;
    localparam int IDX_W  = 4;
    localparam int IMM_W  = 32;
    localparam int RES_W  = 32;

    // Data-processing opcodes in their standard encoding.
    typedef enum logic [CMD_W-1:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } op_t;

    // Condition flags, negative in the top bit down to overflow in the bottom bit.
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

endpackage

// ===== src/rae_if.sv =====
// Channel interfaces of the register ALU execute block: instruction items in, results out.
// Depends on rae_pkg for the field widths.

interface rae_cmd_if;
    import rae_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic             set_flags;
    logic             use_immediate;
    logic [IDX_W-1:0] dest_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] second_reg;
    logic [IMM_W-1:0] immediate_value;

    modport source (
        output valid, command, set_flags, use_immediate,
               dest_reg, first_reg, second_reg, immediate_value,
        input  ready
    );

    modport sink (
        input  valid, command, set_flags, use_immediate,
               dest_reg, first_reg, second_reg, immediate_value,
        output ready
    );
endinterface

interface rae_res_if;
    import rae_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;
    logic             wrote_dest;
    logic             flag_negative;
    logic             flag_zero;
    logic             flag_carry;
    logic             flag_overflow;

    modport source (
        output valid, result_value, wrote_dest,
               flag_negative, flag_zero, flag_carry, flag_overflow,
        input  ready
    );

    modport sink (
        input  valid, result_value, wrote_dest,
               flag_negative, flag_zero, flag_carry, flag_overflow,
        output ready
    );
endinterface

// ===== src/register_alu_execute.sv =====
// Register ALU execute: an item passes the execute stage, then the output register. Throughput
// is one item per cycle unless the output stalls; register file reads are registered, and a result
// written back at the edge of a read is forwarded into the execute stage.
// Reset clears the condition flags, the pipeline and output valids and the per-entry valid
// bits; a register never written since reset reads as zero. No clearing pass is needed.
// Depends on rae_pkg and on the interfaces in rae_if.sv.

module register_alu_execute (
    input logic    clk,
    input logic    rst_n,
    rae_cmd_if.sink   cmd,
    rae_res_if.source res
);
    import rae_pkg::*;

    // Register file memory and its per-entry valid bits.
    logic [DATA_WIDTH-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]  valid_reg;

    // Execute stage: decoded fields of the item in flight.
    logic                  s1_valid_reg;
    op_t                   s1_cmd_reg;
    logic                  s1_set_flags_reg;
    logic                  s1_use_imm_reg;
    logic [IDX_W-1:0]      s1_dest_reg;
    logic [DATA_WIDTH-1:0] s1_imm_reg;

    // Operand read data and forwarding captured at the accepting edge.
    logic [DATA_WIDTH-1:0] rd_a_reg;
    logic [DATA_WIDTH-1:0] rd_b_reg;
    logic                  a_live_reg;
    logic                  b_live_reg;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;

    // Condition flags.
    flags_t flags_reg;
    flags_t flags_next;

    // Output register.
    logic             out_valid_reg;
    logic [RES_W-1:0] out_result_reg;
    logic             out_wrote_reg;
    flags_t           out_flags_reg;

    // Handshake and execute signals.
    logic                  accept;
    logic                  s1_fire;
    logic                  cmd_ready;
    logic                  first_in_range;
    logic                  second_in_range;
    logic                  dest_in_range;
    logic                  wr_en;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] add_x;
    logic [DATA_WIDTH-1:0] add_y;
    logic                  add_cin;
    logic [DATA_WIDTH:0]   add_sum;
    logic                  add_v;
    logic                  is_arith;
    logic                  is_test;
    logic                  flag_update;
    logic [DATA_WIDTH-1:0] alu_result;

    // Handshake: the execute stage advances whenever the output register can take its item.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd_ready = !s1_valid_reg || s1_fire;
    assign cmd.ready = cmd_ready;
    assign accept    = cmd.valid && cmd_ready;

    // Address decode for the read ports and the write port.
    assign first_in_range  = (32'(cmd.first_reg) < REG_COUNT);
    assign second_in_range = (32'(cmd.second_reg) < REG_COUNT);
    assign dest_in_range   = (32'(s1_dest_reg) < REG_COUNT);
    assign rd_addr_a       = ADDR_W'(cmd.first_reg);
    assign rd_addr_b       = ADDR_W'(cmd.second_reg);
    assign wr_addr         = ADDR_W'(s1_dest_reg);
    assign wr_en           = s1_fire && !is_test && dest_in_range;

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= alu_result;
        end
        if (accept)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Entry valid bits: an entry not yet written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Execute stage fields, operand qualifiers and the forwarding of a same-edge write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg       <= op_t'(cmd.command);
            s1_set_flags_reg <= cmd.set_flags;
            s1_use_imm_reg   <= cmd.use_immediate;
            s1_dest_reg      <= cmd.dest_reg;
            s1_imm_reg       <= DATA_WIDTH'(cmd.immediate_value);
            a_live_reg       <= first_in_range && valid_reg[rd_addr_a];
            b_live_reg       <= second_in_range && valid_reg[rd_addr_b];
            fwd_a_reg        <= wr_en && first_in_range && (s1_dest_reg == cmd.first_reg);
            fwd_b_reg        <= wr_en && second_in_range && (s1_dest_reg == cmd.second_reg);
            fwd_data_reg     <= alu_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    // Operand selection: immediate (second operand only), then forwarded write data, then the memory word.
    always_comb
    begin
        if (fwd_a_reg)
        begin
            op_a = fwd_data_reg;
        end
        else
        begin
            op_a = a_live_reg ? rd_a_reg : '0;
        end

        if (s1_use_imm_reg)
        begin
            op_b = s1_imm_reg;
        end
        else if (fwd_b_reg)
        begin
            op_b = fwd_data_reg;
        end
        else
        begin
            op_b = b_live_reg ? rd_b_reg : '0;
        end
    end

    // Shared adder; subtraction adds the inverted operand with a carry in.
    always_comb
    begin
        is_arith = 1'b1;
        add_x    = op_a;
        add_y    = op_b;
        add_cin  = 1'b0;
        case (s1_cmd_reg)
            OP_SUB, OP_CMP:
            begin
                add_y   = ~op_b;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_x   = op_b;
                add_y   = ~op_a;
                add_cin = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                add_cin = 1'b0;
            end
            OP_ADC:
            begin
                add_cin = flags_reg.c;
            end
            OP_SBC:
            begin
                add_y   = ~op_b;
                add_cin = flags_reg.c;
            end
            OP_RSC:
            begin
                add_x   = op_b;
                add_y   = ~op_a;
                add_cin = flags_reg.c;
            end
            default:
            begin
                is_arith = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_WIDTH{1'b0}}, add_cin};
        add_v   = (add_x[DATA_WIDTH-1] ^ add_sum[DATA_WIDTH-1])
                & (add_y[DATA_WIDTH-1] ^ add_sum[DATA_WIDTH-1]);
    end

    // Result selection.
    always_comb
    begin
        case (s1_cmd_reg)
            OP_AND, OP_TST: alu_result = op_a & op_b;
            OP_EOR, OP_TEQ: alu_result = op_a ^ op_b;
            OP_ORR:         alu_result = op_a | op_b;
            OP_MOV:         alu_result = op_b;
            OP_BIC:         alu_result = op_a & ~op_b;
            OP_MVN:         alu_result = ~op_b;
            default:        alu_result = add_sum[DATA_WIDTH-1:0];
        endcase
    end

    // Flag update: tests always set flags, other ops only when asked; logical ops keep C and V.
    always_comb
    begin
        is_test     = s1_cmd_reg inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
        flag_update = is_test || s1_set_flags_reg;
        flags_next  = flags_reg;
        if (flag_update)
        begin
            flags_next.n = alu_result[DATA_WIDTH-1];
            flags_next.z = (alu_result == '0);
            if (is_arith)
            begin
                flags_next.c = add_sum[DATA_WIDTH];
                flags_next.v = add_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (s1_fire)
        begin
            flags_reg <= flags_next;
        end
    end

    // Output register: takes a new item while the previous one is being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_result_reg <= RES_W'(alu_result);
            out_wrote_reg  <= !is_test;
            out_flags_reg  <= flags_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.result_value  = out_result_reg;
    assign res.wrote_dest    = out_wrote_reg;
    assign res.flag_negative = out_flags_reg.n;
    assign res.flag_zero     = out_flags_reg.z;
    assign res.flag_carry    = out_flags_reg.c;
    assign res.flag_overflow = out_flags_reg.v;

    // An item that leaves the execute stage is offered at the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> res.valid)
        else $error("executed item did not reach the output register");

    // Flags hold across an item that does not update them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !flag_update) |=> $stable(flags_reg))
        else $error("condition flags changed without an update");

    // No new item is taken while the execute stage is blocked by a full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !res.ready) |-> !cmd.ready)
        else $error("item accepted while the execute stage is stalled");

endmodule
